>>> hdl/mmc3mc_pkg.sv
// ----------------------------------------------------------------------------
// mmc3mc_pkg: shared types and constants of the MMC3 multicart bank mapper
// Holds the input mode codes, result kinds, address decode values, the
// PRG mode mask table and the job record passed from front to back.
// ----------------------------------------------------------------------------
package mmc3mc_pkg;

  // Depth of the job queue between the decode front and the emit back.
  localparam int unsigned QueueDepth = 4;

  // Input transaction kinds.
  localparam logic [1:0] MODE_OUTER = 2'd0;
  localparam logic [1:0] MODE_MMC3  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_PRG = 2'd0;
  localparam logic [1:0] KIND_CHR = 2'd1;
  localparam logic [1:0] KIND_MIR = 2'd2;
  localparam logic [1:0] KIND_IRQ = 2'd3;

  // Outer register addresses.
  localparam logic [15:0] ADDR_OUTER_MODE = 16'h5FF0;
  localparam logic [15:0] ADDR_PRG_OUTER  = 16'h5FF1;
  localparam logic [15:0] ADDR_CHR_OUTER  = 16'h5FF2;

  // MMC3 register decode.
  localparam logic [15:0] DEC_MASK       = 16'hE001;
  localparam logic [15:0] DEC_BANK_SEL   = 16'h8000;
  localparam logic [15:0] DEC_BANK_DATA  = 16'h8001;
  localparam logic [15:0] DEC_MIRROR     = 16'hA000;
  localparam logic [15:0] DEC_IRQ_LATCH  = 16'hC000;
  localparam logic [15:0] DEC_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] DEC_IRQ_OFF    = 16'hE000;
  localparam logic [15:0] DEC_IRQ_ON     = 16'hE001;

  localparam logic [8:0] LAST_COUNTED_LINE = 9'd240;

  // Reset values of the outer registers.
  localparam logic [7:0] RST_OUTER_MODE = 8'h24;
  localparam logic [7:0] RST_PRG_OUTER  = 8'd159;

  // Fixed PRG bank values of the last two windows.
  localparam logic [7:0] PRG_FIXED_LAST   = 8'hFF;
  localparam logic [7:0] PRG_FIXED_SECOND = 8'hFE;

  // Bit of the outer mode that turns off CHR updates.
  localparam int unsigned ChrOffBit = 5;

  // Result steps of a full update run: four PRG steps, then eight CHR steps.
  // Step 0: PRG window 5 from entry 7.  Step 1: PRG window 7, fixed last.
  // Step 2: PRG window 6 or 4 from entry 6.  Step 3: the other, fixed second.
  // Steps 4..11: CHR windows in run order.
  localparam int unsigned NumSteps = 12;
  localparam int unsigned StepW    = 4;
  localparam int unsigned NumPrgSteps = 4;
  localparam logic [NumSteps-1:0] STEPS_PRG = 12'h00F;
  localparam logic [NumSteps-1:0] STEPS_CHR = 12'hFF0;

  // PRG value mask chosen by the low three bits of the outer mode.
  function automatic logic [5:0] mode_mask(input logic [2:0] m);
    logic [5:0] r;
    case (m)
      3'd0:    r = 6'd63;
      3'd1:    r = 6'd31;
      3'd2:    r = 6'd15;
      3'd3:    r = 6'd1;
      3'd4:    r = 6'd3;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // One queued job: either a single special result or a set of run steps,
  // together with the mapping state that the steps read.
  typedef struct packed {
    logic                special;
    logic [1:0]          spec_kind;
    logic                spec_bit;
    logic [NumSteps-1:0] steps;
    logic                prg_swap;
    logic                chr_hi;
    logic [5:0]          mask;
    logic [7:0]          prg_outer;
    logic [7:0]          chr_outer;
    logic [7:0][7:0]     bank_vals;
  } job_t;

endpackage

>>> hdl/mmc3mc_front.sv
// ----------------------------------------------------------------------------
// mmc3mc_front: input decode and mapper state
// Accepts one CPU write or scanline tick per cycle while in_ready is high,
// updates the bank, outer and IRQ registers, and queues a job of its results.
// ----------------------------------------------------------------------------
module mmc3mc_front
  import mmc3mc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  input  logic        in_rendering_on,
  input  logic [8:0]  in_line_number,
  output logic        push,
  output job_t        job
);

  logic [7:0][7:0] bank_vals_r, bank_vals_nxt;
  logic [7:0] bank_sel_r, bank_sel_nxt;
  logic [7:0] outer_mode_r, outer_mode_nxt;
  logic [7:0] prg_outer_r, prg_outer_nxt;
  logic [7:0] chr_outer_r, chr_outer_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic       irq_on_r, irq_on_nxt;
  logic       pending_r, pending_nxt;

  logic        accept;
  logic [15:0] dec_addr;
  logic        chr_en;
  logic        chr_en_new;
  logic [2:0]  idx;

  assign accept   = in_valid & in_ready;
  assign dec_addr = in_addr & DEC_MASK;
  assign chr_en   = ~outer_mode_r[ChrOffBit];
  assign chr_en_new = ~in_data[ChrOffBit];
  assign idx      = bank_sel_r[2:0];

  // Decode the transaction into next state and a job.
  always_comb begin
    bank_vals_nxt  = bank_vals_r;
    bank_sel_nxt   = bank_sel_r;
    outer_mode_nxt = outer_mode_r;
    prg_outer_nxt  = prg_outer_r;
    chr_outer_nxt  = chr_outer_r;
    irq_count_nxt  = irq_count_r;
    irq_reload_nxt = irq_reload_r;
    irq_on_nxt     = irq_on_r;
    pending_nxt    = pending_r;

    job.special   = 1'b0;
    job.spec_kind = KIND_MIR;
    job.spec_bit  = 1'b0;
    job.steps     = '0;
    job.prg_swap  = bank_sel_r[6];
    job.chr_hi    = bank_sel_r[7];

    case (in_mode)
      MODE_OUTER: begin
        if (in_addr == ADDR_OUTER_MODE) begin
          outer_mode_nxt = in_data;
          job.steps = STEPS_PRG | (chr_en_new ? STEPS_CHR : '0);
        end else if (in_addr == ADDR_PRG_OUTER) begin
          prg_outer_nxt = in_data;
          job.steps = STEPS_PRG;
        end else if (in_addr == ADDR_CHR_OUTER) begin
          chr_outer_nxt = in_data;
          job.steps = chr_en ? STEPS_CHR : '0;
        end
      end
      MODE_MMC3: begin
        case (dec_addr)
          DEC_BANK_SEL: begin
            job.prg_swap = in_data[6];
            job.chr_hi   = in_data[7];
            job.steps = ((in_data[6] != bank_sel_r[6]) ? STEPS_PRG : '0) |
                        ((in_data[7] != bank_sel_r[7]) && chr_en ? STEPS_CHR : '0);
            bank_sel_nxt = in_data;
          end
          DEC_BANK_DATA: begin
            bank_vals_nxt[idx] = in_data;
            case (idx)
              3'd0:    job.steps = chr_en ? 12'h030 : '0;
              3'd1:    job.steps = chr_en ? 12'h0C0 : '0;
              3'd2:    job.steps = chr_en ? 12'h100 : '0;
              3'd3:    job.steps = chr_en ? 12'h200 : '0;
              3'd4:    job.steps = chr_en ? 12'h400 : '0;
              3'd5:    job.steps = chr_en ? 12'h800 : '0;
              3'd6:    job.steps = 12'h004;
              default: job.steps = 12'h001;
            endcase
          end
          DEC_MIRROR: begin
            job.special   = 1'b1;
            job.spec_kind = KIND_MIR;
            job.spec_bit  = in_data[0];
          end
          DEC_IRQ_LATCH: begin
            irq_reload_nxt = in_data;
            if (pending_r) begin
              irq_count_nxt = in_data;
            end
          end
          DEC_IRQ_RELOAD: begin
            pending_nxt   = 1'b1;
            irq_count_nxt = irq_reload_r;
          end
          DEC_IRQ_OFF, DEC_IRQ_ON: begin
            irq_on_nxt = (dec_addr == DEC_IRQ_ON);
            if (pending_r) begin
              irq_count_nxt = irq_reload_r;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_TICK: begin
        if (irq_on_r && in_rendering_on && (in_line_number <= LAST_COUNTED_LINE)) begin
          pending_nxt   = (irq_count_r == 8'd0);
          irq_count_nxt = irq_count_r - 8'd1;
          if (irq_count_r == 8'd0) begin
            job.special   = 1'b1;
            job.spec_kind = KIND_IRQ;
          end
        end
      end
      default: begin
      end
    endcase

    // The job carries the state as it stands after this transaction.
    job.mask      = mode_mask(outer_mode_nxt[2:0]);
    job.prg_outer = prg_outer_nxt;
    job.chr_outer = chr_outer_nxt;
    job.bank_vals = bank_vals_nxt;
  end

  assign push = accept & (job.special | (|job.steps));

  // Mapper state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_vals_r  <= {8'd1, 56'd0};
      bank_sel_r   <= '0;
      outer_mode_r <= RST_OUTER_MODE;
      prg_outer_r  <= RST_PRG_OUTER;
      chr_outer_r  <= '0;
      irq_count_r  <= '0;
      irq_reload_r <= '0;
      irq_on_r     <= 1'b0;
      pending_r    <= 1'b0;
    end else if (accept) begin
      bank_vals_r  <= bank_vals_nxt;
      bank_sel_r   <= bank_sel_nxt;
      outer_mode_r <= outer_mode_nxt;
      prg_outer_r  <= prg_outer_nxt;
      chr_outer_r  <= chr_outer_nxt;
      irq_count_r  <= irq_count_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_on_r     <= irq_on_nxt;
      pending_r    <= pending_nxt;
    end
  end

endmodule

>>> hdl/mmc3mc_fifo.sv
// ----------------------------------------------------------------------------
// mmc3mc_fifo: job queue
// A small first-in first-out queue of jobs between the decode front and the
// emit back; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mmc3mc_fifo
  import mmc3mc_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CntW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/mmc3mc_back.sv
// ----------------------------------------------------------------------------
// mmc3mc_back: result emitter
// Walks the steps of the job at the head of the queue, one result per cycle
// while out_ready allows; registers each PRG or CHR bank or special result.
// ----------------------------------------------------------------------------
module mmc3mc_back
  import mmc3mc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic [11:0] out_bank,
  output logic        out_last
);

  logic                out_valid_r;
  logic [1:0]          kind_r;
  logic [2:0]          slot_r;
  logic [11:0]         bank_r;
  logic                last_r;
  logic                started_r;
  logic [NumSteps-1:0] rem_r;

  logic                advance;
  logic [NumSteps-1:0] cur;
  logic [NumSteps-1:0] rem_nxt;
  logic [StepW-1:0]    step;
  logic [2:0]          chr_k;
  logic [2:0]          chr_idx;
  logic [8:0]          val;
  logic                done;
  logic [1:0]          kind_nxt;
  logic [2:0]          slot_nxt;
  logic [11:0]         bank_nxt;

  assign advance = ~out_valid_r | out_ready;
  assign cur     = started_r ? rem_r : head.steps;

  // Lowest pending step of the current job.
  always_comb begin
    step = '0;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (cur[i]) begin
        step = StepW'(i);
      end
    end
  end

  assign rem_nxt = cur & ~(NumSteps'(1) << step);
  assign done    = head.special | (rem_nxt == '0);
  assign chr_k   = 3'(step - StepW'(NumPrgSteps));
  assign chr_idx = chr_k - 3'd2;

  // Result of the selected step.
  always_comb begin
    val      = '0;
    slot_nxt = '0;
    kind_nxt = KIND_PRG;
    bank_nxt = '0;
    if (head.special) begin
      kind_nxt = head.spec_kind;
      bank_nxt = {11'd0, head.spec_bit};
    end else if (step < StepW'(NumPrgSteps)) begin
      case (step[1:0])
        2'd0: begin
          slot_nxt = 3'd5;
          val      = {1'b0, head.bank_vals[7]};
        end
        2'd1: begin
          slot_nxt = 3'd7;
          val      = {1'b0, PRG_FIXED_LAST};
        end
        2'd2: begin
          slot_nxt = head.prg_swap ? 3'd6 : 3'd4;
          val      = {1'b0, head.bank_vals[6]};
        end
        default: begin
          slot_nxt = head.prg_swap ? 3'd4 : 3'd6;
          val      = {1'b0, PRG_FIXED_SECOND};
        end
      endcase
      bank_nxt = {3'd0, {1'b0, val[7:0] & {2'd0, head.mask}} | {head.prg_outer, 1'b0}};
    end else begin
      kind_nxt = KIND_CHR;
      slot_nxt = {head.chr_hi, 2'b00} ^ chr_k;
      case (chr_k)
        3'd0:    val = {1'b0, head.bank_vals[0]};
        3'd1:    val = {1'b0, head.bank_vals[0]} + 9'd1;
        3'd2:    val = {1'b0, head.bank_vals[1]};
        3'd3:    val = {1'b0, head.bank_vals[1]} + 9'd1;
        default: val = {1'b0, head.bank_vals[chr_idx]};
      endcase
      bank_nxt = {3'd0, val} + {1'b0, head.chr_outer, 3'b000};
    end
  end

  assign pop = advance & ~empty & done;

  // Control: output valid and progress through the head job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      rem_r       <= '0;
    end else if (advance) begin
      out_valid_r <= ~empty;
      if (!empty) begin
        started_r <= ~done;
        rem_r     <= rem_nxt;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      kind_r <= kind_nxt;
      slot_r <= slot_nxt;
      bank_r <= bank_nxt;
      last_r <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_slot  = slot_r;
  assign out_bank  = bank_r;
  assign out_last  = last_r;

endmodule

>>> hdl/mmc3_multicart_bank_mapper_unit.sv
// Path: an accepted transaction's job is queued; the emitter registers each result.
// Throughput: one input transaction per cycle while the job queue has room; the
// emitter gives one result per cycle while out_tready is high; an outer mode write
// or a bank select that flips both swap bits can cause up to 12 results.
// Reset: synchronous, active low; restores the mapper registers to their power-on
// values and empties the job queue without emitting any result.
// ----------------------------------------------------------------------------
// mmc3_multicart_bank_mapper_unit: MMC3 multicart bank mapper
// Decodes CPU writes and scanline ticks in the front, queues jobs and emits
// PRG, CHR, mirroring and IRQ results from the back.
// ----------------------------------------------------------------------------
module mmc3_multicart_bank_mapper_unit
  import mmc3mc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // addr[15:0], data[23:16], rendering_on[24],
                                  // line_number[33:25], zero fill [39:34]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // slot[2:0], bank[14:3], zero fill [15]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);

  logic push;
  logic pop;
  logic empty;
  logic full;
  job_t push_job;
  job_t head;
  logic [2:0]  out_slot;
  logic [11:0] out_bank;

  assign in_tready = ~full;

  // Decode front.
  mmc3mc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_mode         (in_tuser),
    .in_addr         (in_tdata[15:0]),
    .in_data         (in_tdata[23:16]),
    .in_rendering_on (in_tdata[24]),
    .in_line_number  (in_tdata[33:25]),
    .push            (push),
    .job             (push_job)
  );

  // Job queue.
  mmc3mc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Result emitter.
  mmc3mc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_slot  (out_slot),
    .out_bank  (out_bank),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_bank, out_slot};

endmodule

>>> tb/mmc3_map_checker.sv
// ----------------------------------------------------------------------------
// mmc3_map_checker: scoreboard for the MMC3 multicart bank mapper
// Watches both stream channels, keeps its own copy of the mapper registers,
// works out the bank updates that every accepted input transaction causes and
// compares each accepted result transaction with the oldest one still due.
// ----------------------------------------------------------------------------
module mmc3_map_checker
  import mmc3mc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // addr[15:0], data[23:16], rendering_on[24],
                                  // line_number[33:25], zero fill [39:34]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // slot[2:0], bank[14:3], zero fill [15]
  input  logic [1:0]  out_tuser,  // kind[1:0]
  input  logic        out_tlast,
  output int          error_count,
  output int          updates_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // PRG value masks, indexed by the low three bits of the outer mode.
  localparam logic [7:0][7:0] PRG_MASKS = {8'd0, 8'd0, 8'd0, 8'd3,
                                           8'd1, 8'd15, 8'd31, 8'd63};

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [11:0] bank;
    logic        last;
  } bank_update_t;

  // Bank updates predicted but not yet seen on the result channel.
  bank_update_t updates_q[$];

  // Mirror of the mapper registers.
  logic [7:0] bank_vals [8];
  logic [7:0] bank_sel;
  logic [7:0] outer_mode;
  logic [7:0] prg_outer;
  logic [7:0] chr_outer;
  logic [7:0] irq_count;
  logic [7:0] irq_reload_val;
  logic       irq_on;
  logic       reload_pending;

  task automatic report_error(input string msg);
    // Keep the log short when the block is badly broken; every error still counts.
    if (error_count < 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic restore_registers();
    foreach (bank_vals[i]) begin
      bank_vals[i] = 8'd0;
    end
    bank_vals[7]   = 8'd1;
    bank_sel       = 8'd0;
    outer_mode     = RST_OUTER_MODE;
    prg_outer      = RST_PRG_OUTER;
    chr_outer      = 8'd0;
    irq_count      = 8'd0;
    irq_reload_val = 8'd0;
    irq_on         = 1'b0;
    reload_pending = 1'b0;
  endtask

  task automatic queue_update(input logic [1:0] kind, input logic [2:0] slot,
                              input logic [11:0] bank);
    bank_update_t u;
    u.kind = kind;
    u.slot = slot;
    u.bank = bank;
    u.last = 1'b0;
    updates_q.push_back(u);
  endtask

  // PRG bank: value under the mode mask, with the outer bank above it.
  function automatic logic [11:0] prg_bank_of(input logic [7:0] v);
    logic [11:0] masked;
    masked = {4'b0000, v & PRG_MASKS[outer_mode[2:0]]};
    return masked | {3'b000, prg_outer, 1'b0};
  endfunction

  // One CHR 1K window, offset by eight banks per CHR outer step.
  task automatic chr_window(input logic [2:0] slot, input logic [8:0] v);
    if (!outer_mode[ChrOffBit]) begin
      queue_update(KIND_CHR, slot, {3'b000, v} + {1'b0, chr_outer, 3'b000});
    end
  endtask

  task automatic chr_pair(input logic [2:0] slot, input logic [7:0] v);
    chr_window(slot, {1'b0, v});
    chr_window(slot + 3'd1, {1'b0, v} + 9'd1);
  endtask

  // Full PRG refresh; bit 6 of the select byte swaps windows 4 and 6.
  task automatic prg_sweep(input logic [7:0] sel);
    queue_update(KIND_PRG, 3'd5, prg_bank_of(bank_vals[7]));
    queue_update(KIND_PRG, 3'd7, prg_bank_of(PRG_FIXED_LAST));
    if (sel[6]) begin
      queue_update(KIND_PRG, 3'd6, prg_bank_of(bank_vals[6]));
      queue_update(KIND_PRG, 3'd4, prg_bank_of(PRG_FIXED_SECOND));
    end else begin
      queue_update(KIND_PRG, 3'd4, prg_bank_of(bank_vals[6]));
      queue_update(KIND_PRG, 3'd6, prg_bank_of(PRG_FIXED_SECOND));
    end
  endtask

  // Full CHR refresh; bit 7 of the select byte swaps the two 4K halves.
  task automatic chr_sweep(input logic [7:0] sel);
    logic [2:0] base;
    base = {sel[7], 2'b00};
    chr_pair(base, bank_vals[0]);
    chr_pair(base ^ 3'd2, bank_vals[1]);
    chr_window(base ^ 3'd4, {1'b0, bank_vals[2]});
    chr_window(base ^ 3'd5, {1'b0, bank_vals[3]});
    chr_window(base ^ 3'd6, {1'b0, bank_vals[4]});
    chr_window(base ^ 3'd7, {1'b0, bank_vals[5]});
  endtask

  // Update the register mirror for one input transaction and queue its results.
  task automatic predict_item(input logic [1:0] mode, input logic [15:0] addr,
                              input logic [7:0] data, input logic rend,
                              input logic [8:0] line);
    int           first;
    logic [2:0]   base;
    bank_update_t tail;
    first = updates_q.size();
    base  = {bank_sel[7], 2'b00};
    case (mode)
      MODE_OUTER: begin
        if (addr == ADDR_OUTER_MODE) begin
          outer_mode = data;
          prg_sweep(bank_sel);
          chr_sweep(bank_sel);
        end else if (addr == ADDR_PRG_OUTER) begin
          prg_outer = data;
          prg_sweep(bank_sel);
        end else if (addr == ADDR_CHR_OUTER) begin
          chr_outer = data;
          chr_sweep(bank_sel);
        end
      end
      MODE_MMC3: begin
        case (addr & DEC_MASK)
          DEC_BANK_SEL: begin
            if (data[6] != bank_sel[6]) begin
              prg_sweep(data);
            end
            if (data[7] != bank_sel[7]) begin
              chr_sweep(data);
            end
            bank_sel = data;
          end
          DEC_BANK_DATA: begin
            bank_vals[bank_sel[2:0]] = data;
            case (bank_sel[2:0])
              3'd0:    chr_pair(base, data);
              3'd1:    chr_pair(base ^ 3'd2, data);
              3'd2:    chr_window(base ^ 3'd4, {1'b0, data});
              3'd3:    chr_window(base ^ 3'd5, {1'b0, data});
              3'd4:    chr_window(base ^ 3'd6, {1'b0, data});
              3'd5:    chr_window(base ^ 3'd7, {1'b0, data});
              3'd6:    queue_update(KIND_PRG, bank_sel[6] ? 3'd6 : 3'd4, prg_bank_of(data));
              default: queue_update(KIND_PRG, 3'd5, prg_bank_of(data));
            endcase
          end
          DEC_MIRROR: begin
            queue_update(KIND_MIR, 3'd0, {11'd0, data[0]});
          end
          DEC_IRQ_LATCH: begin
            irq_reload_val = data;
            if (reload_pending) begin
              irq_count = irq_reload_val;
            end
          end
          DEC_IRQ_RELOAD: begin
            reload_pending = 1'b1;
            irq_count      = irq_reload_val;
          end
          DEC_IRQ_OFF: begin
            irq_on = 1'b0;
            if (reload_pending) begin
              irq_count = irq_reload_val;
            end
          end
          DEC_IRQ_ON: begin
            irq_on = 1'b1;
            if (reload_pending) begin
              irq_count = irq_reload_val;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_TICK: begin
        // Only visible scanlines with rendering on clock the counter, while IRQ is on.
        if (irq_on && rend && line <= LAST_COUNTED_LINE) begin
          reload_pending = 1'b0;
          if (irq_count == 8'd0) begin
            queue_update(KIND_IRQ, 3'd0, 12'd0);
            reload_pending = 1'b1;
          end
          irq_count = irq_count - 8'd1;
        end
      end
      default: begin
      end
    endcase
    // Mark the final update of this transaction's run.
    if (updates_q.size() > first) begin
      tail      = updates_q.pop_back();
      tail.last = 1'b1;
      updates_q.push_back(tail);
    end
  endtask

  task automatic check_update();
    bank_update_t want;
    if (updates_q.size() == 0) begin
      report_error($sformatf("result with nothing due: kind %0d slot %0d bank %0d",
                             out_tuser, out_tdata[2:0], out_tdata[14:3]));
    end else begin
      want = updates_q.pop_front();
      if (out_tuser != want.kind) begin
        report_error($sformatf("kind expected %0d, got %0d", want.kind, out_tuser));
      end
      if (out_tdata[2:0] != want.slot) begin
        report_error($sformatf("slot expected %0d, got %0d", want.slot, out_tdata[2:0]));
      end
      if (out_tdata[14:3] != want.bank) begin
        report_error($sformatf("bank expected %0d, got %0d", want.bank, out_tdata[14:3]));
      end
      if (out_tlast != want.last) begin
        report_error($sformatf("last expected %0d, got %0d", want.last, out_tlast));
      end
    end
  endtask

  // Results are checked before the input of the same edge is predicted; a new
  // transaction cannot produce a result in the cycle it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      restore_registers();
      updates_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_update();
      end
      if (in_tvalid && in_tready) begin
        predict_item(in_tuser, in_tdata[15:0], in_tdata[23:16], in_tdata[24],
                     in_tdata[33:25]);
      end
    end
    updates_due <= updates_q.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the MMC3 multicart bank mapper
// Drives outer register writes, MMC3 register writes and scanline ticks into
// the mapper with random gaps, stalls the result channel at random and lets
// the checker compare every bank update; prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_top
  import mmc3mc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 300;
  localparam int TargetItems = 360;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // addr[15:0], data[23:16], rendering_on[24],
                           // line_number[33:25], zero fill [39:34]
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // slot[2:0], bank[14:3], zero fill [15]
  logic [1:0]  out_tuser;  // kind[1:0]
  logic        out_tlast;

  int error_count;
  int updates_due;
  int effective_items;
  bit tight;
  bit hold_req;

  mmc3_multicart_bank_mapper_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  mmc3_map_checker map_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .error_count (error_count),
    .updates_due (updates_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender gap: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (tight) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Address that decodes to the given MMC3 register, other bits random.
  function automatic logic [15:0] reg_addr(input logic [15:0] base);
    return (16'($urandom) & ~DEC_MASK) | base;
  endfunction

  // Offer one transaction and return at the edge where it is accepted.
  // Valid stays high into the next transaction when there is no gap.
  task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
                           input logic [7:0] data, input logic rend,
                           input logic [8:0] line);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, line, rend, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // CPU write; the tick fields carry random values that the block must ignore.
  task automatic cpu_write(input logic [1:0] mode, input logic [15:0] addr,
                           input logic [7:0] data);
    send_item(mode, addr, data, 1'($urandom), 9'($urandom));
    effective_items++;
  endtask

  task automatic tick(input logic rend, input logic [8:0] line);
    send_item(MODE_TICK, 16'($urandom), 8'($urandom), rend, line);
    effective_items++;
  endtask

  // Random scanline: mostly visible lines, sometimes beyond the counted range.
  task automatic random_tick();
    logic [8:0] line;
    line = ($urandom_range(0, 5) != 0) ? 9'($urandom_range(0, 240))
                                       : 9'($urandom_range(241, 511));
    tick($urandom_range(0, 7) != 0, line);
  endtask

  task automatic random_register_write();
    logic [15:0] base;
    case ($urandom_range(0, 7))
      0:       base = DEC_BANK_SEL;
      1:       base = DEC_BANK_DATA;
      2:       base = DEC_MIRROR;
      3:       base = DEC_IRQ_LATCH;
      4:       base = DEC_IRQ_RELOAD;
      5:       base = DEC_IRQ_OFF;
      6:       base = DEC_IRQ_ON;
      default: base = 16'($urandom) & 16'h7FFF;
    endcase
    if (base[15]) begin
      base = reg_addr(base);
    end
    cpu_write(MODE_MMC3, base, 8'($urandom));
  endtask

  // Result-side ready: random styles in stretches, plus one long hold-off.
  initial begin : sink
    int style;
    int span;
    int hold_left;
    bit hold_done;
    style     = 0;
    span      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(10, 150);
        end
        span--;
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("mmc3_multicart_bank_mapper_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int         pick;
    logic [7:0] value;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_OUTER;
    tight           = 1'b0;
    hold_req        = 1'b0;
    effective_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: outer register extremes, CHR turned off and on.
    cpu_write(MODE_OUTER, ADDR_OUTER_MODE, RST_OUTER_MODE);
    cpu_write(MODE_OUTER, ADDR_OUTER_MODE, 8'h00);
    cpu_write(MODE_OUTER, ADDR_PRG_OUTER, 8'hFF);
    cpu_write(MODE_OUTER, ADDR_CHR_OUTER, 8'hFF);
    // Bank select flips of both swap bits, then bank data of CHR and PRG entries.
    cpu_write(MODE_MMC3, DEC_BANK_SEL, 8'hC0);
    cpu_write(MODE_MMC3, DEC_BANK_DATA, 8'hFF);
    cpu_write(MODE_MMC3, 16'h9FFE, 8'h43);
    cpu_write(MODE_MMC3, 16'h9FFF, 8'h00);
    cpu_write(MODE_MMC3, reg_addr(DEC_BANK_SEL), 8'h06);
    cpu_write(MODE_MMC3, reg_addr(DEC_BANK_DATA), 8'hFF);
    cpu_write(MODE_MMC3, reg_addr(DEC_BANK_SEL), 8'h47);
    cpu_write(MODE_MMC3, reg_addr(DEC_BANK_DATA), 8'h80);
    // All mask bits off with CHR suppressed, then the narrowest mask.
    cpu_write(MODE_OUTER, ADDR_OUTER_MODE, 8'hFF);
    cpu_write(MODE_OUTER, ADDR_OUTER_MODE, 8'h03);
    // Mirroring both ways.
    cpu_write(MODE_MMC3, DEC_MIRROR, 8'h01);
    cpu_write(MODE_MMC3, 16'hBFFE, 8'hFE);
    // IRQ: zero reload fires on the first counted line; lines past the
    // visible range and ticks with rendering off do not count.
    cpu_write(MODE_MMC3, DEC_IRQ_LATCH, 8'h00);
    cpu_write(MODE_MMC3, DEC_IRQ_RELOAD, 8'h00);
    cpu_write(MODE_MMC3, DEC_IRQ_ON, 8'h00);
    tick(1'b1, LAST_COUNTED_LINE);
    tick(1'b1, 9'h1FF);
    tick(1'b0, 9'd0);
    cpu_write(MODE_MMC3, DEC_IRQ_OFF, 8'hFF);
    // Ignored transactions: unused mode and an unmapped outer address.
    send_item(2'd3, ADDR_OUTER_MODE, 8'h00, 1'b1, 9'd0);
    send_item(MODE_OUTER, 16'h5FF3, 8'h55, 1'b0, 9'd0);

    // Back-to-back full refreshes while the result side holds off.
    hold_req = 1'b1;
    tight    = 1'b1;
    repeat (10) cpu_write(MODE_OUTER, ADDR_OUTER_MODE, 8'($urandom) & 8'hDF);
    tight = 1'b0;

    // Random sequences, mostly well formed, some noise.
    while (effective_items < TargetItems) begin
      if ($urandom_range(0, 9) == 0) begin
        tight = ~tight;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        cpu_write(MODE_MMC3, reg_addr(DEC_BANK_SEL), 8'($urandom));
        cpu_write(MODE_MMC3, reg_addr(DEC_BANK_DATA), 8'($urandom));
      end else if (pick < 45) begin
        value = 8'($urandom);
        case ($urandom_range(0, 2))
          0: begin
            // Keep CHR updates on most of the time.
            if ($urandom_range(0, 3) != 0) begin
              value[ChrOffBit] = 1'b0;
            end
            cpu_write(MODE_OUTER, ADDR_OUTER_MODE, value);
          end
          1:       cpu_write(MODE_OUTER, ADDR_PRG_OUTER, value);
          default: cpu_write(MODE_OUTER, ADDR_CHR_OUTER, value);
        endcase
      end else if (pick < 65) begin
        value = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        cpu_write(MODE_MMC3, reg_addr(DEC_IRQ_LATCH), value);
        cpu_write(MODE_MMC3, reg_addr(DEC_IRQ_RELOAD), 8'($urandom));
        cpu_write(MODE_MMC3, reg_addr(DEC_IRQ_ON), 8'($urandom));
        repeat ($urandom_range(2, 12)) random_tick();
        if ($urandom_range(0, 3) == 0) begin
          cpu_write(MODE_MMC3, reg_addr(DEC_IRQ_OFF), 8'($urandom));
        end
      end else if (pick < 75) begin
        cpu_write(MODE_MMC3, reg_addr(DEC_MIRROR), 8'($urandom));
      end else if (pick < 88) begin
        random_register_write();
      end else begin
        send_item(2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                  9'($urandom));
      end
    end
    tight = 1'b0;
    in_tvalid <= 1'b0;

    // Drain the results still due, then keep watching for stray ones before the verdict.
    @(posedge clk);
    while (updates_due != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (error_count == 0 && updates_due == 0) begin
      $display("mmc3_multicart_bank_mapper_unit verification clean");
    end else begin
      $display("mmc3_multicart_bank_mapper_unit verification failed");
    end
    $finish;
  end

endmodule
